// ===== hdl/sid_pkg.sv =====
// ----------------------------------------------------------------------------
// sid_pkg: shared types for the signed integer divider
// Holds the control bundle that the row builds from the sequencer's load
// and step and from its own final borrow, and drives into the bit-slice cells.
// ----------------------------------------------------------------------------
package sid_pkg;

    // Control that every cell of the row sees in the same cycle.
    typedef struct packed {
        logic load;   // Take fresh operand bits, clear the partial remainder.
        logic step;   // Perform one shift-and-subtract iteration.
        logic take;   // The trial subtraction fits: keep the difference.
    } sid_ctrl_t;

endpackage

// ===== hdl/sid_cell.sv =====
// ----------------------------------------------------------------------------
// sid_cell: one bit slice of the long-division datapath
// Holds one bit each of the partial remainder, of the combined
// dividend/quotient shift register and of the divisor, and forms one bit
// of the trial subtraction with a borrow passed up the row.
// ----------------------------------------------------------------------------
module sid_cell
    import sid_pkg::*;
(
    input  logic      clk,
    input  sid_ctrl_t ctrl,
    input  logic      num_bit,     // Dividend magnitude bit, used on load.
    input  logic      den_bit,     // Divisor magnitude bit, used on load.
    input  logic      rem_in,      // Remainder bit shifted in from below.
    input  logic      nq_in,       // Dividend/quotient bit shifted in from below.
    input  logic      borrow_in,
    output logic      borrow_out,
    output logic      rem_bit,
    output logic      nq_bit
);

    logic rem_reg;
    logic rem_next;
    logic nq_reg;
    logic nq_next;
    logic den_reg;
    logic den_next;
    logic diff;

    // The shifted remainder bit of this slice is the one coming from below.
    assign diff       = rem_in ^ den_reg ^ borrow_in;
    assign borrow_out = (~rem_in & den_reg) | (~(rem_in ^ den_reg) & borrow_in);

    always_comb
    begin
        rem_next = rem_reg;
        nq_next  = nq_reg;
        den_next = den_reg;
        if (ctrl.load)
        begin
            rem_next = 1'b0;
            nq_next  = num_bit;
            den_next = den_bit;
        end
        else if (ctrl.step)
        begin
            rem_next = ctrl.take ? diff : rem_in;
            nq_next  = nq_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        nq_reg  <= nq_next;
        den_reg <= den_next;
    end

    assign rem_bit = rem_reg;
    assign nq_bit  = nq_reg;

endmodule

// ===== hdl/sid_row.sv =====
// ----------------------------------------------------------------------------
// sid_row: chain of bit-slice cells forming the restoring divider
// Each step shifts the remainder and dividend left by one slice, tries the
// subtraction of the divisor across the row and shifts the new quotient bit
// into the bottom of the dividend/quotient register.
// ----------------------------------------------------------------------------
module sid_row
    import sid_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  load,
    input  logic                  step,
    input  logic [DATA_WIDTH-1:0] num_mag,
    input  logic [DATA_WIDTH-1:0] den_mag,
    output logic [DATA_WIDTH-1:0] quot_mag
);

    logic [DATA_WIDTH-1:0] rem_bits;
    logic [DATA_WIDTH-1:0] nq_bits;
    logic [DATA_WIDTH-1:0] rem_shift;
    logic [DATA_WIDTH-1:0] nq_shift;
    logic [DATA_WIDTH:0]   borrow;
    sid_ctrl_t             ctrl;

    // The dividend bit leaving the top of the shift register enters the
    // remainder; a subtraction without final borrow yields a quotient one.
    assign rem_shift = {rem_bits[DATA_WIDTH-2:0], nq_bits[DATA_WIDTH-1]};
    assign nq_shift  = {nq_bits[DATA_WIDTH-2:0], ctrl.take};
    assign borrow[0] = 1'b0;

    assign ctrl.load = load;
    assign ctrl.step = step;
    assign ctrl.take = ~borrow[DATA_WIDTH];

    for (genvar i = 0; i < DATA_WIDTH; i++)
    begin : g_cell
        sid_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .num_bit    (num_mag[i]),
            .den_bit    (den_mag[i]),
            .rem_in     (rem_shift[i]),
            .nq_in      (nq_shift[i]),
            .borrow_in  (borrow[i]),
            .borrow_out (borrow[i+1]),
            .rem_bit    (rem_bits[i]),
            .nq_bit     (nq_bits[i])
        );
    end

    assign quot_mag = nq_bits;

endmodule

// ===== hdl/signed_integer_divider.sv =====
// ----------------------------------------------------------------------------
// signed_integer_divider: signed restoring divider, quotient toward zero
// Divides two signed words using a row of bit-slice cells and fixes the
// sign of the quotient afterwards.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. An operand beat is taken in ST_IDLE, the
// row of DATA_WIDTH cells then resolves one quotient bit per cycle in ST_DIV,
// and ST_FIX applies the sign and loads the output register. As the single
// shift-and-subtract row is shared by all bits, a new operand beat is not
// taken before the previous division is through. The next operand beat is
// taken as soon as the result has moved to the output register, even if that
// result has not yet been taken; a result still held in the output register
// stalls the sign cycle of the next division. The most negative value
// divided by minus one saturates to the largest positive value. A zero
// divisor gives a quotient of zero with tuser set.
module signed_integer_divider
    import sid_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // numerator [DATA_WIDTH-1:0], denominator [2*DATA_WIDTH-1:DATA_WIDTH]
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // quotient [DATA_WIDTH-1:0]
    output logic [((DATA_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
    // zero_divisor
    output logic                               m_axis_tuser
);

    localparam int CW    = $clog2(DATA_WIDTH);
    localparam int OUT_W = ((DATA_WIDTH + 7) / 8) * 8;
    localparam logic [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIX
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic                  zero_reg;
    logic                  zero_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [DATA_WIDTH-1:0] quot_reg;
    logic [DATA_WIDTH-1:0] quot_next;
    logic                  flag_reg;
    logic                  flag_next;

    logic [DATA_WIDTH-1:0] numerator;
    logic [DATA_WIDTH-1:0] denominator;
    logic [DATA_WIDTH-1:0] num_mag;
    logic [DATA_WIDTH-1:0] den_mag;
    logic [DATA_WIDTH-1:0] quot_mag;
    logic [DATA_WIDTH-1:0] quot_fixed;
    logic                  in_beat;
    logic                  load;
    logic                  step;
    logic                  out_free;

    assign numerator   = s_axis_tdata[DATA_WIDTH-1:0];
    assign denominator = s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
    assign num_mag     = numerator[DATA_WIDTH-1] ? (~numerator + 1'b1) : numerator;
    assign den_mag     = denominator[DATA_WIDTH-1] ? (~denominator + 1'b1) : denominator;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign load          = in_beat;
    assign step          = (state_reg == ST_DIV);
    assign out_free      = !out_valid_reg || m_axis_tready;

    sid_row #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_row (
        .clk      (clk),
        .load     (load),
        .step     (step),
        .num_mag  (num_mag),
        .den_mag  (den_mag),
        .quot_mag (quot_mag)
    );

    // A positive result with the top bit set only arises from the most
    // negative value over minus one, and saturates.
    always_comb
    begin
        if (zero_reg)
            quot_fixed = '0;
        else if (neg_reg)
            quot_fixed = ~quot_mag + 1'b1;
        else if (quot_mag[DATA_WIDTH-1])
            quot_fixed = SMAX;
        else
            quot_fixed = quot_mag;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        neg_next       = neg_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg;
        quot_next      = quot_reg;
        flag_next      = flag_reg;

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    neg_next   = numerator[DATA_WIDTH-1] ^ denominator[DATA_WIDTH-1];
                    zero_next  = (denominator == '0);
                    count_next = CW'(DATA_WIDTH - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                count_next = count_reg - 1'b1;
                if (count_reg == '0)
                    state_next = ST_FIX;
            end
            ST_FIX:
            begin
                if (out_free)
                begin
                    quot_next      = quot_fixed;
                    flag_next      = zero_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            neg_reg       <= 1'b0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            quot_reg      <= '0;
            flag_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            neg_reg       <= neg_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
            quot_reg      <= quot_next;
            flag_reg      <= flag_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(quot_reg);
    assign m_axis_tuser  = flag_reg;

endmodule

// ===== tb/signed_integer_divider_tb.sv =====
// ----------------------------------------------------------------------------
// signed_integer_divider_tb: self-checking bench for the signed divider
// Streams operand beats through the divider and predicts every quotient with
// a bit-serial model of truncating signed division. Directed beats cover the
// extremes, every sign combination, overflow saturation and the zero divisor,
// then a mixed random set follows. Both sides idle at random, and the
// receiver stalls once for a long stretch so that the divider backs up.
// ----------------------------------------------------------------------------
module signed_integer_divider_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW       = 32;
    localparam int IN_BITS  = ((2*DW+7)/8)*8;
    localparam int OUT_BITS = ((DW+7)/8)*8;

    localparam logic [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] MOST_POS = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MINUS_ONE = {DW{1'b1}};

    localparam int IDLE_PCT    = 37;
    localparam int CALM_FIRST  = 300;
    localparam int CALM_LAST   = 420;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 500;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 650;

    typedef struct packed {
        logic [DW-1:0] denominator;
        logic [DW-1:0] numerator;
    } div_operands_t;

    typedef struct packed {
        logic [DW-1:0] quotient;
        logic          zero_divisor;
    } quot_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // numerator [31:0], denominator [63:32]
    logic [IN_BITS-1:0]  s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // quotient [31:0]
    logic [OUT_BITS-1:0] m_axis_tdata;
    // zero_divisor
    logic                m_axis_tuser;

    div_operands_t operand_queue[$];
    quot_result_t  quotient_queue[$];
    quot_result_t  due;

    int n_accepted = 0;
    int n_results = 0;
    int n_errors = 0;
    int n_directed = 0;
    int n_total = 0;
    int n_zero_div = 0;
    int n_overflow = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;

    signed_integer_divider #(
        .DATA_WIDTH(DW)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Restoring division on the magnitudes, one quotient bit per pass, with
    // the sign applied at the end. The most negative value has magnitude
    // 2^(DW-1), which still fits as an unsigned word.
    function automatic quot_result_t divide_toward_zero(logic [DW-1:0] num,
                                                        logic [DW-1:0] den);
        logic [DW-1:0] num_mag;
        logic [DW-1:0] den_mag;
        logic [DW-1:0] quo;
        logic [DW:0]   partial;
        quot_result_t  res;
        num_mag = num[DW-1] ? -num : num;
        den_mag = den[DW-1] ? -den : den;
        res = '0;
        if (den_mag == '0)
        begin
            res.zero_divisor = 1'b1;
            return res;
        end
        partial = '0;
        quo = '0;
        for (int i = DW - 1; i >= 0; i--)
        begin
            partial = {partial[DW-1:0], num_mag[i]};
            if (partial >= {1'b0, den_mag})
            begin
                partial = partial - {1'b0, den_mag};
                quo[i] = 1'b1;
            end
        end
        if (num[DW-1] != den[DW-1])
            quo = -quo;
        else if (quo > MOST_POS)
            quo = MOST_POS;
        res.quotient = quo;
        return res;
    endfunction

    function automatic logic [DW-1:0] rand_signed_small(int unsigned limit);
        logic [DW-1:0] mag;
        mag = $urandom_range(limit);
        return $urandom_range(1) ? -mag : mag;
    endfunction

    function automatic logic [DW-1:0] rand_word();
        return $urandom;
    endfunction

    task automatic queue_operands(logic [DW-1:0] num, logic [DW-1:0] den);
        div_operands_t op;
        op.numerator = num;
        op.denominator = den;
        operand_queue.push_back(op);
        n_total++;
        if (den == '0)
            n_zero_div++;
        if (num == MOST_NEG && den == MINUS_ONE)
            n_overflow++;
    endtask

    // Driver: a new beat is offered only once the previous one has gone.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                quotient_queue.push_back(divide_toward_zero(s_axis_tdata[DW-1:0],
                                                            s_axis_tdata[2*DW-1:DW]));
                n_accepted <= n_accepted + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (operand_queue.size() > 0 &&
                    ((n_accepted >= CALM_FIRST && n_accepted < CALM_LAST) ||
                     $urandom_range(99) >= IDLE_PCT))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_BITS'(operand_queue.pop_front());
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: every result beat is checked against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (quotient_queue.size() == 0)
                begin
                    $error("result beat with nothing expected: quotient %0d zero_divisor %0b",
                           $signed(m_axis_tdata[DW-1:0]), m_axis_tuser);
                    n_errors++;
                end
                else
                begin
                    due = quotient_queue.pop_front();
                    if (m_axis_tdata[DW-1:0] !== due.quotient)
                    begin
                        $error("quotient mismatch: expected %0d, actual %0d",
                               $signed(due.quotient), $signed(m_axis_tdata[DW-1:0]));
                        n_errors++;
                    end
                    if (m_axis_tuser !== due.zero_divisor)
                    begin
                        $error("zero_divisor mismatch: expected %0b, actual %0b",
                               due.zero_divisor, m_axis_tuser);
                        n_errors++;
                    end
                end
                n_results <= n_results + 1;
            end
            m_axis_tready <= (hold_left == 0) &&
                             ((n_results >= CALM_FIRST && n_results < CALM_LAST) ||
                              $urandom_range(99) >= IDLE_PCT);
        end
    end

    // One long receiver stall, so the divider fills and stops taking operands.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && n_results == HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    initial
    begin
        // Directed: extremes, all sign combinations, overflow, zero divisor.
        queue_operands(32'sd0, 32'sd1);
        queue_operands(32'sd1, 32'sd1);
        queue_operands(MINUS_ONE, 32'sd1);
        queue_operands(32'sd7, 32'sd2);
        queue_operands(-32'sd7, 32'sd2);
        queue_operands(32'sd7, -32'sd2);
        queue_operands(-32'sd7, -32'sd2);
        queue_operands(MOST_NEG, MINUS_ONE);
        queue_operands(MOST_NEG, 32'sd1);
        queue_operands(MOST_NEG, MOST_NEG);
        queue_operands(MOST_POS, MOST_NEG);
        queue_operands(MOST_POS, 32'sd1);
        queue_operands(MOST_POS, MINUS_ONE);
        queue_operands(MOST_NEG, MOST_POS);
        queue_operands(MOST_POS, MOST_POS);
        queue_operands(32'sd1, MOST_NEG);
        queue_operands(MINUS_ONE, MINUS_ONE);
        queue_operands(32'sd3, 32'sd7);
        queue_operands(-32'sd3, 32'sd7);
        queue_operands(32'sd5, 32'sd0);
        queue_operands(32'sd0, 32'sd0);
        queue_operands(MOST_NEG, 32'sd0);
        queue_operands(MOST_POS, 32'sd0);
        queue_operands(MINUS_ONE, 32'sd0);
        n_directed = n_total;

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            int unsigned pick;
            pick = $urandom_range(99);
            if (pick < 40)
                queue_operands(rand_word(), rand_word());
            else if (pick < 60)
                queue_operands(rand_word(), rand_signed_small(255) | 32'd1);
            else if (pick < 72)
                queue_operands(rand_signed_small(1000), rand_signed_small(1000));
            else if (pick < 78)
                queue_operands(rand_word(), 32'd0);
            else if (pick < 84)
                queue_operands($urandom_range(1) ? MOST_NEG : rand_word(),
                               $urandom_range(1) ? MINUS_ONE : 32'sd1);
            else if (pick < 92)
                queue_operands(rand_signed_small(5000), rand_word());
            else
            begin
                case ($urandom_range(3))
                    0: queue_operands(MOST_NEG, rand_word());
                    1: queue_operands(MOST_POS, rand_word());
                    2: queue_operands(32'd0, rand_word());
                    default: queue_operands(MINUS_ONE, rand_word());
                endcase
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (n_accepted < n_total || quotient_queue.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Divided %0d operand pairs (%0d directed, %0d random), %0d results checked.",
                 n_total, n_directed, n_total - n_directed, n_results);
        $display("Included %0d zero divisors and %0d overflow cases, %0d mismatches.",
                 n_zero_div, n_overflow, n_errors);
        if (n_errors == 0 && quotient_queue.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timed out with %0d of %0d beats accepted, %0d results.",
                 n_accepted, n_total, n_results);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
